FILE: rtl/mts_pkg.sv
// shared types and codes of the multicore task scheduler
package mts_pkg;

  // default sizes
  localparam int TABLE_DEPTH_DEF = 16;
  localparam int CORE_COUNT_DEF  = 4;
  localparam int TIME_BITS_DEF   = 16;

  // task status codes
  localparam logic [1:0] ST_READY = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DONE  = 2'd2;

  // scheduling policies
  localparam logic [1:0] POL_FIFO  = 2'd0;
  localparam logic [1:0] POL_SJF   = 2'd1;
  localparam logic [1:0] POL_RR    = 2'd2;
  localparam logic [1:0] POL_HOLD  = 2'd3;

  // configuration register indexes
  localparam logic CFG_POLICY = 1'b0;
  localparam logic CFG_SLICE  = 1'b1;

  // input operations
  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // input word
  typedef struct packed {
    logic        operation;
    logic [7:0]  task_id;
    logic [15:0] task_length;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [1:0]  core_number;
    logic        core_idle;
    logic [7:0]  running_id;
    logic [15:0] ticks_left;
    logic        finished;
    logic        last_core;
  } out_word_t;

  // table write data select
  typedef enum logic [2:0] {
    WS_NEW, WS_RUN, WS_TICK, WS_READY, WS_RDATA, WS_HOLD
  } wsel_t;

  // core register operations
  typedef enum logic [2:0] {
    CO_NONE, CO_TAKE, CO_TICK, CO_PREEMPT, CO_ROT, CO_SHIFT, CO_KEYLD, CO_KEYPUT
  } coreop_t;

  // result emission
  typedef enum logic [1:0] {
    EM_NONE, EM_IDLE, EM_TICK
  } emit_t;

  // controller to datapath commands
  typedef struct packed {
    logic    rd_en;
    logic    wr_en;
    wsel_t   wr_sel;
    logic    hold_ld;
    coreop_t core_op;
    emit_t   emit;
    logic    cnt_inc;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [1:0] policy;
    logic       cur_busy;
    logic       rd_ready;
    logic       rd_gt;
    logic       preempt;
    logic       full;
  } stat_t;

endpackage

FILE: rtl/multicore_task_scheduler.sv
// top level of the multicore task scheduler
// An add word is taken without raising busy and gives no result. A tick word keeps busy
// high through a fill pass, a report pass and, but for the hold policy, a refill
// pass over the cores, each ready-task scan reading the table entries in order;
// shortest-first adds an insertion sort of the table before the refill pass, and
// each round robin preemption a rotate of the table. The task table memory has one
// read and one write port, and reads or moves one entry per cycle. A tick gives
// CORE_COUNT result words in core order,
// each shown for one cycle with out_valid; they cannot be held off.
module multicore_task_scheduler #(
  parameter int TABLE_DEPTH = mts_pkg::TABLE_DEPTH_DEF,
  parameter int CORE_COUNT  = mts_pkg::CORE_COUNT_DEF,
  parameter int TIME_BITS   = mts_pkg::TIME_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  mts_pkg::in_word_t  in_data,
  output logic               out_valid,
  output mts_pkg::out_word_t out_data,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW  = $clog2(TABLE_DEPTH + 1);
  localparam int CIW = (CORE_COUNT > 1) ? $clog2(CORE_COUNT) : 1;

  mts_pkg::cmd_t  cmd;
  mts_pkg::stat_t stat;
  logic [AW-1:0]  rd_addr, wr_addr, slot_a, slot_b, cur_slot;
  logic [CIW-1:0] core_idx;
  logic [CW-1:0]  count;

  // sequencer
  mts_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .CORE_COUNT (CORE_COUNT)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_op   (in_data.operation),
    .stat    (stat),
    .count   (count),
    .cur_slot(cur_slot),
    .busy    (busy),
    .cmd     (cmd),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .slot_a  (slot_a),
    .slot_b  (slot_b),
    .core_idx(core_idx)
  );

  // table and core state
  mts_datapath #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .CORE_COUNT (CORE_COUNT),
    .TIME_BITS  (TIME_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .rd_addr  (rd_addr),
    .wr_addr  (wr_addr),
    .slot_a   (slot_a),
    .slot_b   (slot_b),
    .core_idx (core_idx),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .stat     (stat),
    .count    (count),
    .cur_slot (cur_slot),
    .out_valid(out_valid),
    .out_data (out_data)
  );

endmodule

FILE: rtl/mts_datapath.sv
// task table memory, core registers, configuration and result registers
module mts_datapath #(
  parameter int TABLE_DEPTH = mts_pkg::TABLE_DEPTH_DEF,
  parameter int CORE_COUNT  = mts_pkg::CORE_COUNT_DEF,
  parameter int TIME_BITS   = mts_pkg::TIME_BITS_DEF,
  localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int CW  = $clog2(TABLE_DEPTH + 1),
  localparam int CIW = (CORE_COUNT > 1) ? $clog2(CORE_COUNT) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  mts_pkg::cmd_t     cmd,
  input  logic [AW-1:0]     rd_addr,
  input  logic [AW-1:0]     wr_addr,
  input  logic [AW-1:0]     slot_a,
  input  logic [AW-1:0]     slot_b,
  input  logic [CIW-1:0]    core_idx,
  input  mts_pkg::in_word_t in_data,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [15:0]       cfg_data,
  output mts_pkg::stat_t    stat,
  output logic [CW-1:0]     count,
  output logic [AW-1:0]     cur_slot,
  output logic              out_valid,
  output mts_pkg::out_word_t out_data
);

  localparam int EW      = 8 + 2 * TIME_BITS + 2;
  localparam int LEFT_LO = 2;
  localparam int TOT_LO  = 2 + TIME_BITS;
  localparam int ID_LO   = 2 + 2 * TIME_BITS;

  logic [EW-1:0]        table_r [TABLE_DEPTH];
  logic [EW-1:0]        rd_data_r;
  logic [EW-1:0]        hold_r;
  logic [EW-1:0]        wr_data;
  logic [CW-1:0]        count_r;
  logic [1:0]           policy_r;
  logic [15:0]          slice_r;
  logic [CORE_COUNT-1:0] busy_r;
  logic [CORE_COUNT-1:0] keymask_r;
  logic [AW-1:0]        slot_r [CORE_COUNT];
  logic [TIME_BITS-1:0] mark_r [CORE_COUNT];
  logic                 out_valid_r;
  mts_pkg::out_word_t   out_data_r;

  logic [TIME_BITS-1:0] rd_left, rd_tot, hold_tot, dec, ran, cur_mark, tl;
  logic [TIME_BITS+15:0] tl_wide, dec_wide;
  logic [CIW+1:0]       cn_wide;
  logic [15:0]          q16;
  logic                 fin, last;
  logic [CW-1:0]        cnt_m1;
  logic [AW-1:0]        rot_top;

  // field views of the read word
  assign rd_left  = rd_data_r[LEFT_LO +: TIME_BITS];
  assign rd_tot   = rd_data_r[TOT_LO +: TIME_BITS];
  assign hold_tot = hold_r[TOT_LO +: TIME_BITS];
  assign dec      = (rd_left != '0) ? rd_left - 1'b1 : '0;
  assign fin      = (dec == '0);
  assign tl_wide  = {{TIME_BITS{1'b0}}, in_data.task_length};
  assign tl       = tl_wide[TIME_BITS-1:0];
  assign dec_wide = {16'b0, dec};
  assign cn_wide  = {2'b00, core_idx};
  assign last     = (core_idx == CIW'(CORE_COUNT - 1));
  assign cnt_m1   = count_r - 1'b1;
  assign rot_top  = cnt_m1[AW-1:0];

  // round robin slice check for the selected core
  assign cur_mark = mark_r[core_idx];
  assign ran      = (cur_mark >= rd_left) ? cur_mark - rd_left : '0;
  assign q16      = (slice_r == 16'd0) ? 16'd1 : slice_r;

  assign stat.policy   = policy_r;
  assign stat.cur_busy = busy_r[core_idx];
  assign stat.rd_ready = (rd_data_r[1:0] == mts_pkg::ST_READY);
  assign stat.rd_gt    = (rd_tot > hold_tot);
  assign stat.preempt  = ({16'b0, ran} >= {{TIME_BITS{1'b0}}, q16});
  assign stat.full     = (count_r == CW'(TABLE_DEPTH));
  assign count         = count_r;
  assign cur_slot      = slot_r[core_idx];
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;

  // table write data
  always_comb begin
    case (cmd.wr_sel)
      mts_pkg::WS_NEW:   wr_data = {in_data.task_id, tl, tl, mts_pkg::ST_READY};
      mts_pkg::WS_RUN:   wr_data = {rd_data_r[EW-1:2], mts_pkg::ST_RUN};
      mts_pkg::WS_TICK:  wr_data = {rd_data_r[EW-1:TOT_LO], dec,
                                    fin ? mts_pkg::ST_DONE : rd_data_r[1:0]};
      mts_pkg::WS_READY: wr_data = {rd_data_r[EW-1:2], mts_pkg::ST_READY};
      mts_pkg::WS_RDATA: wr_data = rd_data_r;
      mts_pkg::WS_HOLD:  wr_data = hold_r;
      default:           wr_data = rd_data_r;
    endcase
  end

  // task table memory
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      table_r[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= table_r[rd_addr];
    end
    if (cmd.hold_ld) begin
      hold_r <= rd_data_r;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    case (cmd.emit)
      mts_pkg::EM_IDLE: begin
        out_data_r <= '{core_number: cn_wide[1:0], core_idle: 1'b1, running_id: 8'd0,
                        ticks_left: 16'd0, finished: 1'b0, last_core: last};
      end
      mts_pkg::EM_TICK: begin
        out_data_r <= '{core_number: cn_wide[1:0], core_idle: 1'b0,
                        running_id: rd_data_r[ID_LO +: 8], ticks_left: dec_wide[15:0],
                        finished: fin, last_core: last};
      end
      default: out_data_r <= out_data_r;
    endcase
  end

  // control registers, configuration and cores
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      policy_r    <= mts_pkg::POL_FIFO;
      slice_r     <= 16'd4;
      out_valid_r <= 1'b0;
      busy_r      <= '0;
      keymask_r   <= '0;
      for (int k = 0; k < CORE_COUNT; k++) begin
        slot_r[k] <= '0;
        mark_r[k] <= '0;
      end
    end else begin
      out_valid_r <= (cmd.emit != mts_pkg::EM_NONE);
      if (cmd.cnt_inc) begin
        count_r <= count_r + 1'b1;
      end
      if (cfg_we) begin
        if (cfg_index == mts_pkg::CFG_POLICY) begin
          policy_r <= cfg_data[1:0];
        end else begin
          slice_r <= cfg_data;
        end
      end
      case (cmd.core_op)
        mts_pkg::CO_TAKE: begin
          slot_r[core_idx] <= slot_a;
          busy_r[core_idx] <= 1'b1;
          mark_r[core_idx] <= rd_left;
        end
        mts_pkg::CO_TICK: begin
          if (fin) begin
            busy_r[core_idx] <= 1'b0;
          end
        end
        mts_pkg::CO_PREEMPT: busy_r[core_idx] <= 1'b0;
        mts_pkg::CO_ROT: begin
          for (int k = 0; k < CORE_COUNT; k++) begin
            if (busy_r[k]) begin
              slot_r[k] <= (slot_r[k] == '0) ? rot_top : slot_r[k] - 1'b1;
            end
          end
        end
        mts_pkg::CO_SHIFT: begin
          for (int k = 0; k < CORE_COUNT; k++) begin
            if (busy_r[k] && !keymask_r[k] && slot_r[k] == slot_a) begin
              slot_r[k] <= slot_b;
            end
          end
        end
        mts_pkg::CO_KEYLD: begin
          for (int k = 0; k < CORE_COUNT; k++) begin
            keymask_r[k] <= busy_r[k] && (slot_r[k] == slot_a);
          end
        end
        mts_pkg::CO_KEYPUT: begin
          for (int k = 0; k < CORE_COUNT; k++) begin
            if (keymask_r[k]) begin
              slot_r[k] <= slot_b;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/mts_ctrl.sv
// sequencer for add, tick, sort, rotate and ready-task scans
module mts_ctrl #(
  parameter int TABLE_DEPTH = mts_pkg::TABLE_DEPTH_DEF,
  parameter int CORE_COUNT  = mts_pkg::CORE_COUNT_DEF,
  localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int CW  = $clog2(TABLE_DEPTH + 1),
  localparam int CIW = (CORE_COUNT > 1) ? $clog2(CORE_COUNT) : 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           in_op,
  input  mts_pkg::stat_t stat,
  input  logic [CW-1:0]  count,
  input  logic [AW-1:0]  cur_slot,
  output logic           busy,
  output mts_pkg::cmd_t  cmd,
  output logic [AW-1:0]  rd_addr,
  output logic [AW-1:0]  wr_addr,
  output logic [AW-1:0]  slot_a,
  output logic [AW-1:0]  slot_b,
  output logic [CIW-1:0] core_idx
);

  typedef enum logic [4:0] {
    S_IDLE, S_A_CORE, S_A_NEXT, S_TR_START, S_TR_CHK, S_B_CORE, S_B_UPD,
    S_SO_INIT, S_SO_KEY, S_SO_CMP, S_SO_PUT, S_C_CORE, S_C_PRE, S_C_PCHK,
    S_RO_0, S_RO_1, S_RO_LOOP, S_RO_END, S_C_NEXT
  } state_t;

  state_t         state_r, state_nxt, ret_r, ret_nxt;
  logic [CIW-1:0] c_r, c_nxt;
  logic [CW-1:0]  i_r, i_nxt, j_r, j_nxt;
  logic [CW-1:0]  i_inc, i_m1, j_m1, j_m2, cnt_m1;
  logic           last_c;

  assign busy     = (state_r != S_IDLE);
  assign core_idx = c_r;
  assign last_c   = (c_r == CIW'(CORE_COUNT - 1));
  assign i_inc    = i_r + 1'b1;
  assign i_m1     = i_r - 1'b1;
  assign j_m1     = j_r - 1'b1;
  assign j_m2     = j_r - CW'(2);
  assign cnt_m1   = count - 1'b1;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    c_nxt     = c_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    cmd       = '{rd_en: 1'b0, wr_en: 1'b0, wr_sel: mts_pkg::WS_RDATA, hold_ld: 1'b0,
                  core_op: mts_pkg::CO_NONE, emit: mts_pkg::EM_NONE, cnt_inc: 1'b0};
    rd_addr   = '0;
    wr_addr   = '0;
    slot_a    = '0;
    slot_b    = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_op == mts_pkg::OP_TICK) begin
            c_nxt     = '0;
            state_nxt = S_A_CORE;
          end else if (!stat.full) begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = mts_pkg::WS_NEW;
            wr_addr     = count[AW-1:0];
            cmd.cnt_inc = 1'b1;
          end
        end
      end
      // fill idle cores before the tick
      S_A_CORE: begin
        if (stat.cur_busy) begin
          state_nxt = S_A_NEXT;
        end else begin
          ret_nxt   = S_A_NEXT;
          state_nxt = S_TR_START;
        end
      end
      S_A_NEXT: begin
        if (last_c) begin
          c_nxt     = '0;
          state_nxt = S_B_CORE;
        end else begin
          c_nxt     = c_r + 1'b1;
          state_nxt = S_A_CORE;
        end
      end
      // scan for the first ready task
      S_TR_START: begin
        if (count == '0) begin
          state_nxt = ret_r;
        end else begin
          cmd.rd_en = 1'b1;
          rd_addr   = '0;
          i_nxt     = '0;
          state_nxt = S_TR_CHK;
        end
      end
      S_TR_CHK: begin
        if (stat.rd_ready) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_sel  = mts_pkg::WS_RUN;
          wr_addr     = i_r[AW-1:0];
          cmd.core_op = mts_pkg::CO_TAKE;
          slot_a      = i_r[AW-1:0];
          state_nxt   = ret_r;
        end else if (i_inc < count) begin
          cmd.rd_en = 1'b1;
          rd_addr   = i_inc[AW-1:0];
          i_nxt     = i_inc;
        end else begin
          state_nxt = ret_r;
        end
      end
      // run one tick on each core and report it
      S_B_CORE: begin
        if (stat.cur_busy) begin
          cmd.rd_en = 1'b1;
          rd_addr   = cur_slot;
          state_nxt = S_B_UPD;
        end else begin
          cmd.emit = mts_pkg::EM_IDLE;
          if (last_c) begin
            c_nxt = '0;
            case (stat.policy)
              mts_pkg::POL_HOLD: state_nxt = S_IDLE;
              mts_pkg::POL_SJF:  state_nxt = S_SO_INIT;
              default:           state_nxt = S_C_CORE;
            endcase
          end else begin
            c_nxt = c_r + 1'b1;
          end
        end
      end
      S_B_UPD: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = mts_pkg::WS_TICK;
        wr_addr     = cur_slot;
        cmd.core_op = mts_pkg::CO_TICK;
        cmd.emit    = mts_pkg::EM_TICK;
        if (last_c) begin
          c_nxt = '0;
          case (stat.policy)
            mts_pkg::POL_HOLD: state_nxt = S_IDLE;
            mts_pkg::POL_SJF:  state_nxt = S_SO_INIT;
            default:           state_nxt = S_C_CORE;
          endcase
        end else begin
          c_nxt     = c_r + 1'b1;
          state_nxt = S_B_CORE;
        end
      end
      // stable insertion sort by total time
      S_SO_INIT: begin
        if (count < CW'(2)) begin
          state_nxt = S_C_CORE;
        end else begin
          cmd.rd_en = 1'b1;
          rd_addr   = AW'(1);
          i_nxt     = CW'(1);
          state_nxt = S_SO_KEY;
        end
      end
      S_SO_KEY: begin
        cmd.hold_ld = 1'b1;
        cmd.core_op = mts_pkg::CO_KEYLD;
        slot_a      = i_r[AW-1:0];
        cmd.rd_en   = 1'b1;
        rd_addr     = i_m1[AW-1:0];
        j_nxt       = i_r;
        state_nxt   = S_SO_CMP;
      end
      S_SO_CMP: begin
        if (stat.rd_gt) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_sel  = mts_pkg::WS_RDATA;
          wr_addr     = j_r[AW-1:0];
          cmd.core_op = mts_pkg::CO_SHIFT;
          slot_a      = j_m1[AW-1:0];
          slot_b      = j_r[AW-1:0];
          j_nxt       = j_m1;
          if (j_m1 != '0) begin
            cmd.rd_en = 1'b1;
            rd_addr   = j_m2[AW-1:0];
          end else begin
            state_nxt = S_SO_PUT;
          end
        end else begin
          state_nxt = S_SO_PUT;
        end
      end
      S_SO_PUT: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = mts_pkg::WS_HOLD;
        wr_addr     = j_r[AW-1:0];
        cmd.core_op = mts_pkg::CO_KEYPUT;
        slot_b      = j_r[AW-1:0];
        i_nxt       = i_inc;
        if (i_inc < count) begin
          cmd.rd_en = 1'b1;
          rd_addr   = i_inc[AW-1:0];
          state_nxt = S_SO_KEY;
        end else begin
          state_nxt = S_C_CORE;
        end
      end
      // refill freed cores
      S_C_CORE: begin
        if (stat.cur_busy) begin
          state_nxt = S_C_PRE;
        end else begin
          ret_nxt   = S_C_PRE;
          state_nxt = S_TR_START;
        end
      end
      S_C_PRE: begin
        if (stat.policy == mts_pkg::POL_RR && stat.cur_busy) begin
          cmd.rd_en = 1'b1;
          rd_addr   = cur_slot;
          state_nxt = S_C_PCHK;
        end else begin
          state_nxt = S_C_NEXT;
        end
      end
      S_C_PCHK: begin
        if (stat.preempt) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_sel  = mts_pkg::WS_READY;
          wr_addr     = cur_slot;
          cmd.core_op = mts_pkg::CO_PREEMPT;
          state_nxt   = S_RO_0;
        end else begin
          state_nxt = S_C_NEXT;
        end
      end
      // rotate the table left by one
      S_RO_0: begin
        cmd.rd_en = 1'b1;
        rd_addr   = '0;
        state_nxt = S_RO_1;
      end
      S_RO_1: begin
        cmd.hold_ld = 1'b1;
        if (count == CW'(1)) begin
          state_nxt = S_RO_END;
        end else begin
          cmd.rd_en = 1'b1;
          rd_addr   = AW'(1);
          i_nxt     = CW'(1);
          state_nxt = S_RO_LOOP;
        end
      end
      S_RO_LOOP: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = mts_pkg::WS_RDATA;
        wr_addr    = i_m1[AW-1:0];
        if (i_inc < count) begin
          cmd.rd_en = 1'b1;
          rd_addr   = i_inc[AW-1:0];
          i_nxt     = i_inc;
        end else begin
          state_nxt = S_RO_END;
        end
      end
      S_RO_END: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = mts_pkg::WS_HOLD;
        wr_addr     = cnt_m1[AW-1:0];
        cmd.core_op = mts_pkg::CO_ROT;
        ret_nxt     = S_C_NEXT;
        state_nxt   = S_TR_START;
      end
      S_C_NEXT: begin
        if (last_c) begin
          c_nxt     = '0;
          state_nxt = S_IDLE;
        end else begin
          c_nxt     = c_r + 1'b1;
          state_nxt = S_C_CORE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and loop registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= S_IDLE;
      c_r     <= '0;
      i_r     <= '0;
      j_r     <= '0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      c_r     <= c_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
    end
  end

endmodule

FILE: rtl/mts_checker.sv
// port-level checks for the multicore task scheduler and their binding
module mts_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input mts_pkg::in_word_t  in_data,
  input logic               out_valid,
  input mts_pkg::out_word_t out_data
);

  // an add word does not raise busy
  a_add_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_data.operation == mts_pkg::OP_ADD |=> !busy)
    else $error("add word left the block busy");

  // a tick word starts a busy period
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_data.operation == mts_pkg::OP_TICK |=> busy)
    else $error("tick word did not start work");

  // an idle core reports no task
  a_idle_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.core_idle |->
      out_data.running_id == 8'd0 && out_data.ticks_left == 16'd0 && !out_data.finished)
    else $error("idle core word carries task data");

  // a finished task has no ticks left
  a_fin_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.finished |-> out_data.ticks_left == 16'd0)
    else $error("finished task with ticks left");

  // reset leaves the block idle and quiet
  a_reset: assert property (@(posedge clk) !rst_n |=> !busy && !out_valid)
    else $error("block not idle after reset");

endmodule

bind multicore_task_scheduler mts_checker u_mts_checker (.*);

FILE: test/tb_multicore_task_scheduler.sv
// testbench for the multicore task scheduler: random add and tick words checked against a model
module tb_multicore_task_scheduler;
  import mts_pkg::*;

  localparam int DEPTH = 16;
  localparam int CORES = 4;
  localparam int WATCHDOG_LIMIT = 20000;

  // schedule tracker with expected core reports
  class sched_board;
    logic [7:0]  t_id[DEPTH];
    logic [15:0] t_total[DEPTH];
    logic [15:0] t_left[DEPTH];
    logic [1:0]  t_stat[DEPTH];
    int          n_tasks;
    int          slot[CORES];
    bit          on[CORES];
    logic [15:0] mark[CORES];
    logic [1:0]  pol;
    logic [15:0] slice;
    out_word_t   pending[$];
    int          errors;
    int          n_checked;

    function new();
      n_tasks = 0;
      pol = POL_FIFO;
      slice = 16'd4;
      errors = 0;
      n_checked = 0;
      foreach (on[c]) begin
        on[c] = 0;
        slot[c] = 0;
        mark[c] = 0;
      end
    endfunction

    function void set_reg(logic idx, logic [15:0] v);
      if (idx == CFG_POLICY) pol = v[1:0];
      else slice = v;
    endfunction

    function void grab(int c);
      for (int i = 0; i < n_tasks; i++) begin
        if (t_stat[i] == ST_READY) begin
          t_stat[i] = ST_RUN;
          slot[c] = i;
          on[c] = 1;
          mark[c] = t_left[i];
          return;
        end
      end
    endfunction

    function void permute(int order[DEPTH]);
      logic [7:0]  nid[DEPTH];
      logic [15:0] ntot[DEPTH];
      logic [15:0] nleft[DEPTH];
      logic [1:0]  nst[DEPTH];
      int          where[DEPTH];
      for (int i = 0; i < n_tasks; i++) begin
        nid[i] = t_id[order[i]];
        ntot[i] = t_total[order[i]];
        nleft[i] = t_left[order[i]];
        nst[i] = t_stat[order[i]];
        where[order[i]] = i;
      end
      for (int i = 0; i < n_tasks; i++) begin
        t_id[i] = nid[i];
        t_total[i] = ntot[i];
        t_left[i] = nleft[i];
        t_stat[i] = nst[i];
      end
      for (int c = 0; c < CORES; c++)
        if (on[c] && slot[c] < n_tasks) slot[c] = where[slot[c]];
    endfunction

    function void refill();
      int          order[DEPTH];
      int          k;
      int          j;
      int          s;
      logic [15:0] q;
      logic [15:0] ran;
      q = (slice == 0) ? 16'd1 : slice;
      if (pol == POL_HOLD) return;
      // stable insertion sort on total time
      if (pol == POL_SJF) begin
        for (int i = 0; i < n_tasks; i++) order[i] = i;
        for (int i = 1; i < n_tasks; i++) begin
          k = order[i];
          j = i;
          while (j > 0 && t_total[order[j-1]] > t_total[k]) begin
            order[j] = order[j-1];
            j--;
          end
          order[j] = k;
        end
        permute(order);
      end
      for (int c = 0; c < CORES; c++) begin
        if (!on[c]) grab(c);
        if (pol == POL_RR && on[c]) begin
          s = slot[c];
          ran = (mark[c] >= t_left[s]) ? mark[c] - t_left[s] : 16'd0;
          if (ran >= q) begin
            t_stat[s] = ST_READY;
            on[c] = 0;
            // rotate the table left by one
            if (n_tasks > 0) begin
              for (int i = 0; i < n_tasks; i++) order[i] = (i + 1) % n_tasks;
              permute(order);
            end
            grab(c);
          end
        end
      end
    endfunction

    // note an accepted input word
    function void note_word(in_word_t w);
      out_word_t r;
      int        s;
      if (w.operation == OP_ADD) begin
        if (n_tasks < DEPTH) begin
          t_id[n_tasks] = w.task_id;
          t_total[n_tasks] = w.task_length;
          t_left[n_tasks] = w.task_length;
          t_stat[n_tasks] = ST_READY;
          n_tasks++;
        end
        return;
      end
      for (int c = 0; c < CORES; c++)
        if (!on[c]) grab(c);
      for (int c = 0; c < CORES; c++) begin
        r = '0;
        r.core_number = c[1:0];
        r.last_core = (c == CORES - 1);
        if (!on[c]) begin
          r.core_idle = 1'b1;
        end else begin
          s = slot[c];
          if (t_left[s] > 0) t_left[s]--;
          r.finished = (t_left[s] == 0);
          if (r.finished) begin
            t_stat[s] = ST_DONE;
            on[c] = 0;
          end
          r.running_id = t_id[s];
          r.ticks_left = t_left[s];
        end
        pending.push_back(r);
      end
      refill();
    endfunction

    // compare a result word with the oldest expectation
    function void check_word(out_word_t got);
      out_word_t want;
      if (pending.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %p", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      n_checked++;
      if (got.core_number !== want.core_number || got.core_idle !== want.core_idle ||
          got.running_id !== want.running_id || got.ticks_left !== want.ticks_left ||
          got.finished !== want.finished || got.last_core !== want.last_core) begin
        $display("%0t mismatch: expected %p, actual %p", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_word_t    in_data;
  logic        out_valid;
  out_word_t   out_data;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;

  sched_board board;
  int         idle_cycles;
  int         n_words;
  int         n_ticks;
  bit         calm;

  multicore_task_scheduler DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // result checking and watchdog
  always @(posedge clk) begin
    if (rst_n && out_valid) board.check_word(out_data);
    if (rst_n && (out_valid || (start && !busy))) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired");
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_reg(logic idx, logic [15:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    board.set_reg(idx, v);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // send one word, sometimes with a random gap ahead of it (never when calm)
  task automatic send_word(logic op, logic [7:0] id, logic [15:0] len);
    in_word_t w;
    int       gap;
    w.operation = op;
    w.task_id = id;
    w.task_length = len;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (busy);
    board.note_word(w);
    n_words++;
    if (op == OP_TICK) n_ticks++;
  endtask

  // wait until no result is outstanding and the block is idle, then let it settle
  task automatic drain();
    start <= 1'b0;
    while (board.pending.size() != 0 || busy) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic send_add_short();
    send_word(OP_ADD, 8'($urandom_range(0, 255)),
              16'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                             : $urandom_range(0, 6)));
  endtask

  initial begin
    logic [1:0] pols[8];
    board = new();
    idle_cycles = 0;
    n_words = 0;
    n_ticks = 0;
    calm = 0;
    start = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_POLICY;
    cfg_data = '0;
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, full table, zero length, idle cores
    send_word(OP_TICK, 8'h00, 16'h0000);
    send_word(OP_ADD, 8'hFF, 16'hFFFF);
    send_word(OP_ADD, 8'h00, 16'h0000);
    send_word(OP_ADD, 8'hA5, 16'h0001);
    send_word(OP_TICK, 8'h5A, 16'h5555);
    send_word(OP_TICK, 8'hFF, 16'hFFFF);
    for (int i = 0; i < 15; i++) send_word(OP_ADD, i[7:0] + 8'h10, 16'd2 + i[15:0]);
    send_word(OP_TICK, 8'h00, 16'h0000);
    drain();
    write_reg(CFG_SLICE, 16'd0);
    write_reg(CFG_POLICY, {14'd0, POL_RR});
    send_word(OP_TICK, 8'h00, 16'h0000);
    send_word(OP_TICK, 8'h00, 16'h0000);
    drain();

    // random phases, each on a fresh table by reset of expectations is not possible,
    // so phases mostly run in policies that keep the table moving
    pols = '{POL_SJF, POL_RR, POL_FIFO, POL_HOLD, POL_RR, POL_SJF, POL_FIFO, POL_RR};
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_POLICY, {14'd0, pols[ph]});
      write_reg(CFG_SLICE, (ph == 3) ? 16'hFFFF : 16'($urandom_range(1, 5)));
      if (ph == 7) calm = 1;
      for (int i = 0; i < 30; i++) begin
        if ($urandom_range(0, 3) == 0) send_add_short();
        else send_word(OP_TICK, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
      end
      drain();
    end

    $display("run covered %0d words, %0d ticks, %0d core reports over all four policies",
             n_words, n_ticks, board.n_checked);
    $display("table full, zero length tasks, zero and maximal slices were exercised");
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

FILE: multicore_task_scheduler.f
rtl/mts_pkg.sv
rtl/mts_datapath.sv
rtl/mts_ctrl.sv
rtl/multicore_task_scheduler.sv
rtl/mts_checker.sv
test/tb_multicore_task_scheduler.sv
